>>> rtl/tdr_pkg.sv
package tdr_pkg;

  // Width of the exact working arithmetic (products, sums and quotients).
  localparam int WIDE_W = 256;

  localparam int WINDOW_DEF = 16;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] FIT_OK    = 2'd0;
  localparam logic [1:0] FIT_NONE  = 2'd1;
  localparam logic [1:0] FIT_DEGEN = 2'd2;

  typedef struct packed {
    logic [63:0] tick;
    logic [63:0] low;
    logic [63:0] high;
  } sample_t;

  typedef struct packed {
    logic start;
    logic sub;
  } mul_ctl_t;

endpackage

>>> rtl/tdr_store.sv
module tdr_store #(
  parameter int WINDOW = tdr_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(WINDOW)-1:0] waddr,
  input  tdr_pkg::sample_t          wdata,
  input  logic [$clog2(WINDOW)-1:0] raddr,
  output tdr_pkg::sample_t          rdata
);

  tdr_pkg::sample_t mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tdr_mul.sv
module tdr_mul #(
  parameter int B_W = 72
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tdr_pkg::mul_ctl_t            ctl,
  input  logic [tdr_pkg::WIDE_W-1:0]   a,
  input  logic [B_W-1:0]               b,
  input  logic [tdr_pkg::WIDE_W-1:0]   init,
  output logic                         done,
  output logic [tdr_pkg::WIDE_W-1:0]   res
);

  localparam int WW  = tdr_pkg::WIDE_W;
  localparam int CNW = $clog2(B_W);

  logic [WW-1:0]  a_r;
  logic [B_W-1:0] b_r;
  logic [WW-1:0]  acc_r;
  logic [CNW-1:0] cnt_r;
  logic           sub_r;
  logic           busy_r;
  logic           done_r;
  logic           last;
  logic           m;
  logic [WW-1:0]  acc_nxt;

  // The top bit of b carries negative weight: its step inverts sub.
  assign last    = (cnt_r == CNW'(B_W - 1));
  assign m       = sub_r ^ last;
  assign acc_nxt = acc_r + (b_r[0] ? (a_r ^ {WW{m}}) : '0) + WW'(b_r[0] & m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= init;
        sub_r  <= ctl.sub;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r + CNW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

>>> rtl/tdr_div.sv
module tdr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tdr_pkg::WIDE_W-1:0] num,
  input  logic [tdr_pkg::WIDE_W-1:0] den,
  output logic                       done,
  output logic [tdr_pkg::WIDE_W-1:0] quo
);

  localparam int WW  = tdr_pkg::WIDE_W;
  localparam int CNW = $clog2(WW);

  logic [WW-1:0]  rem_r;
  logic [WW-1:0]  quo_r;
  logic [WW-1:0]  den_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [WW:0]    shifted;
  logic [WW+1:0]  diff;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_r, quo_r[WW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[WW+1]) begin
          rem_r <= diff[WW-1:0];
        end else begin
          rem_r <= shifted[WW-1:0];
        end
        quo_r <= {quo_r[WW-2:0], ~diff[WW+1]};
        cnt_r <= cnt_r + CNW'(1);
        if (cnt_r == CNW'(WW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/timestamp_date_regression.sv
// Tick-to-date regression. A transfer is taken when start is high and busy is low; exactly
// one result follows, shown on out_date/out_status for the single cycle out_valid is high,
// and the receiver cannot stall it. All products run through one shift-add multiplier
// that retires one bit of its narrow operand per cycle (SW = 67 + clog2(WINDOW+1) bits wide),
// and all quotients run through one restoring divider that retires one quotient bit per cycle.
// A push into a full window first picks and removes the victim before it writes the new
// sample; a push that leaves at least three samples in the window then refits the line.
module timestamp_date_regression #(
  parameter int WINDOW = tdr_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [63:0] in_tick,
  input  logic [63:0] in_date_low,
  input  logic [63:0] in_date_high,
  output logic        out_valid,
  output logic [63:0] out_date,
  output logic [1:0]  out_status
);

  localparam int WW = tdr_pkg::WIDE_W;
  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = 67 + CW;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SH_RD, S_SH_WR, S_WRITE, S_ORG_RD, S_ORG_EV,
    S_PT_RD, S_PT_EV, S_M_XX, S_M_XS, S_M_T1A, S_M_T1B, S_M_T2A, S_M_T2B,
    S_SL_ABS, S_SL_GO, S_SL_DIV, S_B_GO, S_M_B, S_IC_ABS, S_IC_GO, S_IC_DIV,
    S_Q_GO, S_M_Q, S_Q_ABS, S_Q_RND, S_Q_SGN, S_Q_ADD, S_Q_SAT, S_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0]        count_r;
  logic signed [63:0]   slope_r;
  logic signed [63:0]   intercept_r;
  logic [63:0]          origin_tick_r;
  logic [63:0]          origin_date_r;
  logic [1:0]           fit_r;
  logic                 out_valid_r;
  logic [63:0]          out_date_r;
  logic [1:0]           out_status_r;

  logic                 cmd_r;
  tdr_pkg::sample_t     new_r;
  logic [63:0]          date_r;
  logic [AW-1:0]        idx_r;
  logic [AW-1:0]        victim_r;
  logic [63:0]          best_r;
  logic [63:0]          t0_r;
  logic [63:0]          l0_r;
  logic signed [63:0]   x_r;
  logic signed [65:0]   s_r;
  logic signed [SW-1:0] sx_r;
  logic signed [SW-1:0] sy_r;
  logic [WW-1:0]        sxx_r;
  logic [WW-1:0]        sxs_r;
  logic [WW-1:0]        t2_r;
  logic [WW-1:0]        wk_r;
  logic                 neg_r;
  logic signed [63:0]   a64_r;

  tdr_pkg::sample_t     rdata;
  tdr_pkg::sample_t     wdata;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;

  tdr_pkg::mul_ctl_t    mul_ctl;
  logic [WW-1:0]        mul_a;
  logic [SW-1:0]        mul_b;
  logic [WW-1:0]        mul_init;
  logic                 mul_done;
  logic [WW-1:0]        mul_p;

  logic                 div_start;
  logic [WW-1:0]        div_num;
  logic [WW-1:0]        div_den;
  logic                 div_done;
  logic [WW-1:0]        div_q;

  logic signed [63:0]   x_c;
  logic signed [63:0]   dl_c;
  logic signed [63:0]   dh_c;
  logic signed [65:0]   s_c;
  logic signed [63:0]   dq_c;
  logic [63:0]          spread_c;
  logic                 take_c;
  logic                 last_pt;
  logic [SW-1:0]        n_b;
  logic [WW-1:0]        wk_neg;

  function automatic logic [63:0] sat64(input logic [WW-1:0] q, input logic neg);
    logic [63:0] r;
    if (!neg) begin
      r = (|q[WW-1:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
    end else begin
      r = ((|q[WW-1:64]) || (q[63] && (|q[62:0]))) ? 64'h8000_0000_0000_0000
                                                   : (~q[63:0] + 64'd1);
    end
    return r;
  endfunction

  assign busy = (state_r != S_IDLE);

  assign x_c      = rdata.tick - t0_r;
  assign dl_c     = rdata.low - l0_r;
  assign dh_c     = rdata.high - l0_r;
  assign s_c      = 66'(dl_c) + 66'(dh_c);
  assign dq_c     = new_r.tick - origin_tick_r;
  assign spread_c = rdata.high - rdata.low;
  assign take_c   = (rdata.high > rdata.low) && (spread_c > best_r);
  assign last_pt  = (CW'(idx_r) + CW'(1) == count_r);
  assign n_b      = SW'(count_r);
  assign wk_neg   = ~wk_r + WW'(1);

  tdr_store #(.WINDOW(WINDOW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tdr_mul #(.B_W(SW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .init  (mul_init),
    .done  (mul_done),
    .res   (mul_p)
  );

  tdr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    raddr = idx_r;
    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata;
    case (state_r)
      S_SH_RD:  raddr = idx_r + AW'(1);
      S_ORG_RD: raddr = '0;
      S_SH_WR:  we = 1'b1;
      S_WRITE: begin
        we    = 1'b1;
        waddr = count_r[AW-1:0];
        wdata = new_r;
      end
      default: ;
    endcase
  end

  // Multiplier launches; a waiting state may start the next product once its own is done.
  always_comb begin
    mul_ctl  = '0;
    mul_a    = '0;
    mul_b    = '0;
    mul_init = '0;
    case (state_r)
      S_PT_EV: begin
        mul_ctl.start = 1'b1;
        mul_a         = WW'(x_c);
        mul_b         = SW'(x_c);
        mul_init      = sxx_r;
      end
      S_M_XX: begin
        mul_ctl.start = mul_done;
        mul_a         = WW'(x_r);
        mul_b         = SW'(s_r);
        mul_init      = sxs_r;
      end
      S_M_XS: begin
        mul_ctl.start = mul_done && last_pt;
        mul_a         = mul_p;
        mul_b         = n_b;
      end
      S_M_T1A: begin
        mul_ctl.start = mul_done;
        mul_ctl.sub   = 1'b1;
        mul_a         = WW'(sx_r);
        mul_b         = sy_r;
        mul_init      = mul_p;
      end
      S_M_T1B: begin
        mul_ctl.start = mul_done;
        mul_a         = sxx_r;
        mul_b         = n_b;
      end
      S_M_T2A: begin
        mul_ctl.start = mul_done;
        mul_ctl.sub   = 1'b1;
        mul_a         = WW'(sx_r);
        mul_b         = sx_r;
        mul_init      = mul_p;
      end
      S_B_GO: begin
        mul_ctl.start = 1'b1;
        mul_ctl.sub   = 1'b1;
        mul_a         = WW'(sx_r) << 1;
        mul_b         = SW'(a64_r);
        mul_init      = WW'(sy_r) << 40;
      end
      S_Q_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = WW'(dq_c);
        mul_b         = SW'(slope_r);
        mul_init      = WW'(intercept_r) << 24;
      end
      default: ;
    endcase
  end

  // Rounded division as floor((2|n| + d) / 2d) on magnitudes.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_SL_GO: begin
        div_start = 1'b1;
        div_num   = (wk_r << 41) + (t2_r << 1);
        div_den   = t2_r << 2;
      end
      S_IC_GO: begin
        div_start = 1'b1;
        div_num   = (wk_r << 1) + (WW'(count_r) << 25);
        div_den   = WW'(count_r) << 26;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      slope_r       <= '0;
      intercept_r   <= '0;
      origin_tick_r <= '0;
      origin_date_r <= '0;
      fit_r         <= tdr_pkg::FIT_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= in_command;
            new_r.tick <= in_tick;
            new_r.low  <= in_date_low;
            new_r.high <= in_date_high;
            date_r     <= '0;
            best_r     <= '0;
            victim_r   <= '0;
            idx_r      <= '0;
            if (in_command == tdr_pkg::CMD_QUERY) begin
              state_r <= S_Q_GO;
            end else if (count_r == CW'(WINDOW)) begin
              state_r <= S_SCAN_RD;
            end else begin
              state_r <= S_WRITE;
            end
          end
        end
        S_SCAN_RD: state_r <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (take_c) begin
            best_r   <= spread_c;
            victim_r <= idx_r;
          end
          if (idx_r == AW'(WINDOW - 1)) begin
            idx_r   <= take_c ? idx_r : victim_r;
            state_r <= S_SH_RD;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_SCAN_RD;
          end
        end
        S_SH_RD: begin
          if (idx_r == AW'(WINDOW - 1)) begin
            count_r <= CW'(WINDOW - 1);
            state_r <= S_WRITE;
          end else begin
            state_r <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          idx_r   <= idx_r + AW'(1);
          state_r <= S_SH_RD;
        end
        S_WRITE: begin
          count_r <= count_r + CW'(1);
          state_r <= (count_r >= CW'(2)) ? S_ORG_RD : S_DONE;
        end
        S_ORG_RD: state_r <= S_ORG_EV;
        S_ORG_EV: begin
          t0_r    <= rdata.tick;
          l0_r    <= rdata.low;
          sx_r    <= '0;
          sy_r    <= '0;
          sxx_r   <= '0;
          sxs_r   <= '0;
          idx_r   <= '0;
          state_r <= S_PT_RD;
        end
        S_PT_RD: state_r <= S_PT_EV;
        S_PT_EV: begin
          x_r     <= x_c;
          s_r     <= s_c;
          sx_r    <= sx_r + SW'(x_c);
          sy_r    <= sy_r + SW'(s_c);
          state_r <= S_M_XX;
        end
        S_M_XX: begin
          if (mul_done) begin
            sxx_r   <= mul_p;
            state_r <= S_M_XS;
          end
        end
        S_M_XS: begin
          if (mul_done) begin
            sxs_r <= mul_p;
            if (last_pt) begin
              state_r <= S_M_T1A;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= S_PT_RD;
            end
          end
        end
        S_M_T1A: if (mul_done) state_r <= S_M_T1B;
        S_M_T1B: begin
          if (mul_done) begin
            wk_r    <= mul_p;
            neg_r   <= mul_p[WW-1];
            state_r <= S_M_T2A;
          end
        end
        S_M_T2A: if (mul_done) state_r <= S_M_T2B;
        S_M_T2B: begin
          if (mul_done) begin
            t2_r <= mul_p;
            if (mul_p == '0) begin
              if (fit_r != tdr_pkg::FIT_NONE) begin
                fit_r <= tdr_pkg::FIT_DEGEN;
              end
              state_r <= S_DONE;
            end else begin
              state_r <= S_SL_ABS;
            end
          end
        end
        S_SL_ABS: begin
          wk_r    <= neg_r ? wk_neg : wk_r;
          state_r <= S_SL_GO;
        end
        S_SL_GO: state_r <= S_SL_DIV;
        S_SL_DIV: begin
          if (div_done) begin
            a64_r   <= sat64(div_q, neg_r);
            state_r <= S_B_GO;
          end
        end
        S_B_GO: state_r <= S_M_B;
        S_M_B: begin
          if (mul_done) begin
            wk_r    <= mul_p;
            neg_r   <= mul_p[WW-1];
            state_r <= S_IC_ABS;
          end
        end
        S_IC_ABS: begin
          wk_r    <= neg_r ? wk_neg : wk_r;
          state_r <= S_IC_GO;
        end
        S_IC_GO: state_r <= S_IC_DIV;
        S_IC_DIV: begin
          if (div_done) begin
            intercept_r   <= sat64(div_q, neg_r);
            slope_r       <= a64_r;
            origin_tick_r <= t0_r;
            origin_date_r <= l0_r;
            fit_r         <= tdr_pkg::FIT_OK;
            state_r       <= S_DONE;
          end
        end
        S_Q_GO: state_r <= S_M_Q;
        S_M_Q: begin
          if (mul_done) begin
            wk_r    <= mul_p;
            neg_r   <= mul_p[WW-1];
            state_r <= S_Q_ABS;
          end
        end
        S_Q_ABS: begin
          wk_r    <= neg_r ? wk_neg : wk_r;
          state_r <= S_Q_RND;
        end
        S_Q_RND: begin
          wk_r    <= (wk_r + (WW'(1) << 39)) >> 40;
          state_r <= S_Q_SGN;
        end
        S_Q_SGN: begin
          wk_r    <= neg_r ? wk_neg : wk_r;
          state_r <= S_Q_ADD;
        end
        S_Q_ADD: begin
          wk_r    <= wk_r + WW'(origin_date_r);
          state_r <= S_Q_SAT;
        end
        S_Q_SAT: begin
          if (wk_r[WW-1]) begin
            date_r <= '0;
          end else if (|wk_r[WW-2:64]) begin
            date_r <= '1;
          end else begin
            date_r <= wk_r[63:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r  <= 1'b1;
          out_date_r   <= (cmd_r == tdr_pkg::CMD_QUERY) ? date_r : '0;
          out_status_r <= fit_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_date   = out_date_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW))
    else $error("sample count exceeds window");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == tdr_pkg::FIT_OK || out_status == tdr_pkg::FIT_NONE ||
                   out_status == tdr_pkg::FIT_DEGEN))
    else $error("invalid status on result");
`endif

endmodule
